@@ rtl/q2e_pkg.sv @@
// shared constants, types and the arctangent table for the quaternion to euler block
`timescale 1ns / 1ps
`default_nettype none
package q2e_pkg;

    localparam int CORDIC_STAGES_DEF  = 16;
    localparam int QUAT_FRAC_BITS_DEF = 14;
    localparam int ANG_TABLE_LEN      = 24;

    localparam int QUAT_W     = 16;
    localparam int PROD_W     = 2 * QUAT_W;
    localparam int VEC_W      = 36;
    localparam int CORD_W     = 34;
    localparam int ANG_W      = 26;
    localparam int NORM_MSB   = 29;
    localparam int SHIFT_W    = 6;
    localparam int SQRT_W     = 62;
    localparam int SQRT_STEPS = 31;
    localparam int SQRT_TOP   = 60;
    localparam int S30_W      = 31;
    localparam int ROUND_BIAS = 256;
    localparam int ROUND_SH   = 9;

    localparam int YAW_LIM   = 23040;
    localparam int PITCH_LIM = 11520;
    localparam int YAW_W     = 16;
    localparam int PITCH_W   = 15;

    localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(180 * 65536);

    typedef struct packed {
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [ANG_W-1:0]  z;
        logic                     zero;
        logic                     tag;
    } cordic_vec_t;

    typedef struct packed {
        logic [SQRT_W-1:0] n;
        logic [SQRT_W-1:0] res;
        logic [S30_W-1:0]  s30;
        logic              sneg;
        logic              clamp;
    } sqrt_state_t;

    // atan(2^-i) in 2^-16 degree
    function automatic logic signed [ANG_W-1:0] ang_entry(input int idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:       v = ANG_W'(2949120);
            1:       v = ANG_W'(1740967);
            2:       v = ANG_W'(919879);
            3:       v = ANG_W'(466945);
            4:       v = ANG_W'(234379);
            5:       v = ANG_W'(117304);
            6:       v = ANG_W'(58666);
            7:       v = ANG_W'(29335);
            8:       v = ANG_W'(14668);
            9:       v = ANG_W'(7334);
            10:      v = ANG_W'(3667);
            11:      v = ANG_W'(1833);
            12:      v = ANG_W'(917);
            13:      v = ANG_W'(458);
            14:      v = ANG_W'(229);
            15:      v = ANG_W'(115);
            16:      v = ANG_W'(57);
            17:      v = ANG_W'(29);
            18:      v = ANG_W'(14);
            19:      v = ANG_W'(7);
            20:      v = ANG_W'(4);
            21:      v = ANG_W'(2);
            22:      v = ANG_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // round to 1/128 degree and saturate
    function automatic logic signed [ANG_W:0] sat_angle(
        input logic signed [ANG_W-1:0] z,
        input logic                    zero,
        input int                      lim
    );
        logic signed [ANG_W:0] t;
        t = zero ? '0 : ((ANG_W+1)'(z) + (ANG_W+1)'(ROUND_BIAS));
        t = t >>> ROUND_SH;
        if (t > (ANG_W+1)'(lim)) begin
            t = (ANG_W+1)'(lim);
        end
        if (t < -((ANG_W+1)'(lim))) begin
            t = -((ANG_W+1)'(lim));
        end
        return t;
    endfunction

endpackage
`default_nettype wire

@@ rtl/q2e_sqrt_cell.sv @@
// one bit of the integer square root, one step of the chain
`timescale 1ns / 1ps
`default_nettype none
module q2e_sqrt_cell #(
    parameter int BIT_POS = 60
) (
    input  wire                   aclk,
    input  wire                   en,
    input  q2e_pkg::sqrt_state_t  in_st,
    output q2e_pkg::sqrt_state_t  out_st
);

    localparam logic [q2e_pkg::SQRT_W-1:0] BIT_V = q2e_pkg::SQRT_W'(1) << BIT_POS;

    q2e_pkg::sqrt_state_t st_reg, st_next;
    logic [q2e_pkg::SQRT_W-1:0] trial;

    always_comb begin
        trial   = in_st.res + BIT_V;
        st_next = in_st;
        if (in_st.n >= trial) begin
            st_next.n   = in_st.n - trial;
            st_next.res = (in_st.res >> 1) + BIT_V;
        end else begin
            st_next.res = in_st.res >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg <= st_next;
        end
    end

    assign out_st = st_reg;

endmodule
`default_nettype wire

@@ rtl/q2e_norm.sv @@
// folds a vector into the right half plane and scales it to the cordic range
`timescale 1ns / 1ps
`default_nettype none
module q2e_norm (
    input  wire                                 aclk,
    input  wire                                 en,
    input  wire signed [q2e_pkg::VEC_W-1:0]     in_x,
    input  wire signed [q2e_pkg::VEC_W-1:0]     in_y,
    input  wire                                 in_tag,
    output q2e_pkg::cordic_vec_t                out_vec
);

    localparam int VW = q2e_pkg::VEC_W;
    localparam int CW = q2e_pkg::CORD_W;
    localparam int AW = q2e_pkg::ANG_W;
    localparam int SW = q2e_pkg::SHIFT_W;

    // fold stage
    logic signed [VW-1:0] fx, fy;
    logic [VW-1:0]        mx_a_reg, my_a_reg;
    logic                 yneg_a_reg, zero_a_reg, tag_a_reg;
    logic signed [AW-1:0] z_a_reg, z_a_next;

    // leading one stage
    logic [VW-1:0]        m_b;
    logic [SW-1:0]        pos_b;
    logic [VW-1:0]        mx_b_reg, my_b_reg;
    logic                 yneg_b_reg, zero_b_reg, tag_b_reg, rsh_b_reg;
    logic [SW-1:0]        amt_b_reg;
    logic signed [AW-1:0] z_b_reg;

    // shift stage
    logic [VW-1:0]        sx_c, sy_c;
    q2e_pkg::cordic_vec_t vec_reg, vec_next;

    always_comb begin
        fx       = in_x[VW-1] ? -in_x : in_x;
        fy       = in_x[VW-1] ? -in_y : in_y;
        z_a_next = !in_x[VW-1] ? '0 :
                   (in_y[VW-1] ? -q2e_pkg::HALF_TURN : q2e_pkg::HALF_TURN);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mx_a_reg   <= fx;
            my_a_reg   <= fy[VW-1] ? -fy : fy;
            yneg_a_reg <= fy[VW-1];
            zero_a_reg <= (in_x == '0) && (in_y == '0);
            tag_a_reg  <= in_tag;
            z_a_reg    <= z_a_next;
        end
    end

    always_comb begin
        m_b   = (mx_a_reg > my_a_reg) ? mx_a_reg : my_a_reg;
        pos_b = '0;
        for (int i = 0; i < VW; i++) begin
            if (m_b[i]) begin
                pos_b = SW'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mx_b_reg   <= mx_a_reg;
            my_b_reg   <= my_a_reg;
            yneg_b_reg <= yneg_a_reg;
            zero_b_reg <= zero_a_reg;
            tag_b_reg  <= tag_a_reg;
            z_b_reg    <= z_a_reg;
            rsh_b_reg  <= pos_b > SW'(q2e_pkg::NORM_MSB);
            amt_b_reg  <= (pos_b > SW'(q2e_pkg::NORM_MSB)) ?
                          (pos_b - SW'(q2e_pkg::NORM_MSB)) :
                          (SW'(q2e_pkg::NORM_MSB) - pos_b);
        end
    end

    // right shifts truncate the magnitude before the sign goes back on
    always_comb begin
        sx_c          = rsh_b_reg ? (mx_b_reg >> amt_b_reg) : (mx_b_reg << amt_b_reg);
        sy_c          = rsh_b_reg ? (my_b_reg >> amt_b_reg) : (my_b_reg << amt_b_reg);
        vec_next.x    = $signed(CW'(sx_c));
        vec_next.y    = yneg_b_reg ? -$signed(CW'(sy_c)) : $signed(CW'(sy_c));
        vec_next.z    = z_b_reg;
        vec_next.zero = zero_b_reg;
        vec_next.tag  = tag_b_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg <= vec_next;
        end
    end

    assign out_vec = vec_reg;

endmodule
`default_nettype wire

@@ rtl/q2e_cordic_cell.sv @@
// one vectoring rotation of the cordic chain
`timescale 1ns / 1ps
`default_nettype none
module q2e_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire                   aclk,
    input  wire                   en,
    input  q2e_pkg::cordic_vec_t  in_vec,
    output q2e_pkg::cordic_vec_t  out_vec
);

    localparam int CW = q2e_pkg::CORD_W;

    logic signed [CW-1:0] cx, cy, xs, ys;
    q2e_pkg::cordic_vec_t vec_reg, vec_next;

    assign cx = in_vec.x;
    assign cy = in_vec.y;
    assign xs = cx >>> STAGE;
    assign ys = cy >>> STAGE;

    always_comb begin
        vec_next = in_vec;
        if (!cy[CW-1]) begin
            vec_next.x = cx + ys;
            vec_next.y = cy - xs;
            vec_next.z = in_vec.z + q2e_pkg::ang_entry(STAGE);
        end else begin
            vec_next.x = cx - ys;
            vec_next.y = cy + xs;
            vec_next.z = in_vec.z - q2e_pkg::ang_entry(STAGE);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg <= vec_next;
        end
    end

    assign out_vec = vec_reg;

endmodule
`default_nettype wire

@@ rtl/quaternion_to_euler_angles.sv @@
// quaternion to yaw, pitch and roll, fully pipelined cordic
// throughput: one request per cycle; the whole pipeline stalls while a result waits
// the pitch path sets the depth: a 31 step square root chain ahead of the cordic
// reset (synchronous, active low) clears the valid flags only; data needs no reset
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler_angles #(
    parameter int CORDIC_STAGES  = q2e_pkg::CORDIC_STAGES_DEF,
    parameter int QUAT_FRAC_BITS = q2e_pkg::QUAT_FRAC_BITS_DEF
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  wire signed [q2e_pkg::QUAT_W-1:0]      s_quat_w,
    input  wire signed [q2e_pkg::QUAT_W-1:0]      s_quat_x,
    input  wire signed [q2e_pkg::QUAT_W-1:0]      s_quat_y,
    input  wire signed [q2e_pkg::QUAT_W-1:0]      s_quat_z,
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output logic signed [q2e_pkg::YAW_W-1:0]      m_yaw_deg,
    output logic signed [q2e_pkg::PITCH_W-1:0]    m_pitch_deg,
    output logic signed [q2e_pkg::YAW_W-1:0]      m_roll_deg,
    output logic                                  m_pitch_clamped
);

    localparam int PW    = q2e_pkg::PROD_W;
    localparam int VW    = q2e_pkg::VEC_W;
    localparam int QW    = q2e_pkg::SQRT_W;
    localparam int RW    = q2e_pkg::S30_W;
    localparam int AW    = q2e_pkg::ANG_W;
    localparam int K     = 2 * QUAT_FRAC_BITS;
    localparam int SW    = (K + 3 > VW) ? K + 3 : VW;
    localparam int NSTG  = (CORDIC_STAGES > q2e_pkg::ANG_TABLE_LEN) ?
                           q2e_pkg::ANG_TABLE_LEN : CORDIC_STAGES;
    localparam int DLY   = q2e_pkg::SQRT_STEPS + 2;
    localparam int PIPE  = 8 + q2e_pkg::SQRT_STEPS + NSTG;
    localparam logic signed [SW-1:0] ONE = SW'(1) << K;

    logic en;
    logic [PIPE-1:0] vld_reg;
    logic            m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[PIPE-2:0], s_valid};
            m_valid_reg <= vld_reg[PIPE-1];
        end
    end

    // products
    logic signed [PW-1:0] p_ww_reg, p_xx_reg, p_yy_reg, p_zz_reg, p_xy_reg;
    logic signed [PW-1:0] p_wz_reg, p_wx_reg, p_yz_reg, p_xz_reg, p_wy_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_ww_reg <= s_quat_w * s_quat_w;
            p_xx_reg <= s_quat_x * s_quat_x;
            p_yy_reg <= s_quat_y * s_quat_y;
            p_zz_reg <= s_quat_z * s_quat_z;
            p_xy_reg <= s_quat_x * s_quat_y;
            p_wz_reg <= s_quat_w * s_quat_z;
            p_wx_reg <= s_quat_w * s_quat_x;
            p_yz_reg <= s_quat_y * s_quat_z;
            p_xz_reg <= s_quat_x * s_quat_z;
            p_wy_reg <= s_quat_w * s_quat_y;
        end
    end

    // sums
    logic signed [VW-1:0] yaw_y_reg, yaw_x_reg, roll_y_reg, roll_x_reg;
    logic signed [SW-1:0] sin_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            yaw_y_reg  <= (VW'(p_xy_reg) + VW'(p_wz_reg)) <<< 1;
            yaw_x_reg  <= VW'(p_ww_reg) + VW'(p_xx_reg) - VW'(p_yy_reg) - VW'(p_zz_reg);
            roll_y_reg <= (VW'(p_wx_reg) + VW'(p_yz_reg)) <<< 1;
            roll_x_reg <= VW'(p_ww_reg) - VW'(p_xx_reg) - VW'(p_yy_reg) + VW'(p_zz_reg);
            sin_reg    <= (SW'(p_xz_reg) - SW'(p_wy_reg)) <<< 1;
        end
    end

    // saturate the sine argument and bring it to Q30
    logic signed [SW-1:0] sin_c;
    logic                 clamp_c;
    logic [SW-1:0]        sin_mag;
    logic [RW-1:0]        s30_c;

    always_comb begin
        sin_c   = sin_reg;
        clamp_c = 1'b0;
        if (sin_reg > ONE) begin
            sin_c   = ONE;
            clamp_c = 1'b1;
        end else if (sin_reg < -ONE) begin
            sin_c   = -ONE;
            clamp_c = 1'b1;
        end
        sin_mag = sin_c[SW-1] ? SW'(-sin_c) : SW'(sin_c);
    end

    if (K >= 30) begin : g_s30_down
        assign s30_c = RW'(sin_mag >> (K - 30));
    end else begin : g_s30_up
        assign s30_c = RW'(sin_mag << (30 - K));
    end

    logic [RW-1:0]        s30_reg, s30_sq_reg;
    logic                 sneg_reg, clamp_reg, sneg_sq_reg, clamp_sq_reg;
    logic signed [VW-1:0] yaw_y3_reg, yaw_x3_reg, roll_y3_reg, roll_x3_reg;
    logic [QW-1:0]        sq_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s30_reg      <= s30_c;
            sneg_reg     <= sin_c[SW-1];
            clamp_reg    <= clamp_c;
            yaw_y3_reg   <= yaw_y_reg;
            yaw_x3_reg   <= yaw_x_reg;
            roll_y3_reg  <= roll_y_reg;
            roll_x3_reg  <= roll_x_reg;
            sq_reg       <= QW'(s30_reg) * QW'(s30_reg);
            s30_sq_reg   <= s30_reg;
            sneg_sq_reg  <= sneg_reg;
            clamp_sq_reg <= clamp_reg;
        end
    end

    // square root chain for the cosine
    q2e_pkg::sqrt_state_t sq_st[0:q2e_pkg::SQRT_STEPS];
    q2e_pkg::sqrt_state_t sq_init_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_init_reg.n     <= (QW'(1) << q2e_pkg::SQRT_TOP) - sq_reg;
            sq_init_reg.res   <= '0;
            sq_init_reg.s30   <= s30_sq_reg;
            sq_init_reg.sneg  <= sneg_sq_reg;
            sq_init_reg.clamp <= clamp_sq_reg;
        end
    end

    assign sq_st[0] = sq_init_reg;

    for (genvar i = 0; i < q2e_pkg::SQRT_STEPS; i++) begin : g_sqrt
        q2e_sqrt_cell #(
            .BIT_POS (q2e_pkg::SQRT_TOP - 2 * i)
        ) u_cell (
            .aclk   (aclk),
            .en     (en),
            .in_st  (sq_st[i]),
            .out_st (sq_st[i+1])
        );
    end

    // yaw and roll wait for the square root
    logic signed [VW-1:0] dly_yy_reg[0:DLY-1];
    logic signed [VW-1:0] dly_yx_reg[0:DLY-1];
    logic signed [VW-1:0] dly_ry_reg[0:DLY-1];
    logic signed [VW-1:0] dly_rx_reg[0:DLY-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            dly_yy_reg[0] <= yaw_y3_reg;
            dly_yx_reg[0] <= yaw_x3_reg;
            dly_ry_reg[0] <= roll_y3_reg;
            dly_rx_reg[0] <= roll_x3_reg;
            for (int i = 1; i < DLY; i++) begin
                dly_yy_reg[i] <= dly_yy_reg[i-1];
                dly_yx_reg[i] <= dly_yx_reg[i-1];
                dly_ry_reg[i] <= dly_ry_reg[i-1];
                dly_rx_reg[i] <= dly_rx_reg[i-1];
            end
        end
    end

    logic signed [VW-1:0] pitch_y, pitch_x, pitch_s30;
    q2e_pkg::sqrt_state_t sq_out;

    assign sq_out    = sq_st[q2e_pkg::SQRT_STEPS];
    assign pitch_s30 = $signed(VW'(sq_out.s30));
    assign pitch_y   = sq_out.sneg ? -pitch_s30 : pitch_s30;
    assign pitch_x   = $signed(VW'(sq_out.res));

    // three cordic lanes: yaw, pitch, roll
    q2e_pkg::cordic_vec_t yaw_v[0:NSTG];
    q2e_pkg::cordic_vec_t pitch_v[0:NSTG];
    q2e_pkg::cordic_vec_t roll_v[0:NSTG];

    q2e_norm u_norm_yaw (
        .aclk    (aclk),
        .en      (en),
        .in_x    (dly_yx_reg[DLY-1]),
        .in_y    (dly_yy_reg[DLY-1]),
        .in_tag  (1'b0),
        .out_vec (yaw_v[0])
    );

    q2e_norm u_norm_pitch (
        .aclk    (aclk),
        .en      (en),
        .in_x    (pitch_x),
        .in_y    (pitch_y),
        .in_tag  (sq_out.clamp),
        .out_vec (pitch_v[0])
    );

    q2e_norm u_norm_roll (
        .aclk    (aclk),
        .en      (en),
        .in_x    (dly_rx_reg[DLY-1]),
        .in_y    (dly_ry_reg[DLY-1]),
        .in_tag  (1'b0),
        .out_vec (roll_v[0])
    );

    for (genvar i = 0; i < NSTG; i++) begin : g_cordic
        q2e_cordic_cell #(.STAGE(i)) u_yaw (
            .aclk (aclk), .en (en), .in_vec (yaw_v[i]), .out_vec (yaw_v[i+1])
        );
        q2e_cordic_cell #(.STAGE(i)) u_pitch (
            .aclk (aclk), .en (en), .in_vec (pitch_v[i]), .out_vec (pitch_v[i+1])
        );
        q2e_cordic_cell #(.STAGE(i)) u_roll (
            .aclk (aclk), .en (en), .in_vec (roll_v[i]), .out_vec (roll_v[i+1])
        );
    end

    // rounding and output register
    logic signed [AW:0]   yaw_o, pitch_o, roll_o;
    logic signed [AW-1:0] pitch_neg;

    assign pitch_neg = -pitch_v[NSTG].z;
    assign yaw_o   = q2e_pkg::sat_angle(yaw_v[NSTG].z, yaw_v[NSTG].zero, q2e_pkg::YAW_LIM);
    assign pitch_o = q2e_pkg::sat_angle(pitch_neg, pitch_v[NSTG].zero, q2e_pkg::PITCH_LIM);
    assign roll_o  = q2e_pkg::sat_angle(roll_v[NSTG].z, roll_v[NSTG].zero, q2e_pkg::YAW_LIM);

    logic signed [q2e_pkg::YAW_W-1:0]   yaw_reg, roll_reg;
    logic signed [q2e_pkg::PITCH_W-1:0] pitch_reg;
    logic                               clamped_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            yaw_reg     <= q2e_pkg::YAW_W'(yaw_o);
            pitch_reg   <= q2e_pkg::PITCH_W'(pitch_o);
            roll_reg    <= q2e_pkg::YAW_W'(roll_o);
            clamped_reg <= pitch_v[NSTG].tag;
        end
    end

    assign m_yaw_deg       = yaw_reg;
    assign m_pitch_deg     = pitch_reg;
    assign m_roll_deg      = roll_reg;
    assign m_pitch_clamped = clamped_reg;

endmodule
`default_nettype wire

@@ tb/quaternion_to_euler_angles_tb.sv @@
// self-checking testbench for the quaternion to euler angle converter
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler_angles_tb;

    localparam int QUAT_W        = q2e_pkg::QUAT_W;
    localparam int YAW_W         = q2e_pkg::YAW_W;
    localparam int PITCH_W       = q2e_pkg::PITCH_W;
    localparam int ANG_TABLE_LEN = q2e_pkg::ANG_TABLE_LEN;
    localparam int ROUND_BIAS    = q2e_pkg::ROUND_BIAS;
    localparam int ROUND_SH      = q2e_pkg::ROUND_SH;
    localparam int YAW_LIM       = q2e_pkg::YAW_LIM;
    localparam int PITCH_LIM     = q2e_pkg::PITCH_LIM;

    localparam int FRAC      = q2e_pkg::QUAT_FRAC_BITS_DEF;
    localparam int STAGES    = q2e_pkg::CORDIC_STAGES_DEF > ANG_TABLE_LEN ? ANG_TABLE_LEN
                                                                : q2e_pkg::CORDIC_STAGES_DEF;
    localparam int LATENCY   = 40 + STAGES;
    localparam int N_RANDOM  = 1400;
    localparam int CYCLE_CAP = 400000;
    localparam longint HALF  = 180 * 65536;

    typedef struct packed {
        logic signed [YAW_W-1:0]   yaw;
        logic signed [PITCH_W-1:0] pitch;
        logic signed [YAW_W-1:0]   roll;
        logic                      clamped;
    } angles_t;

    typedef struct {
        logic signed [QUAT_W-1:0] w, x, y, z;
        bit                       fixed;
        angles_t                  ang;
    } quat_row_t;

    logic aclk, aresetn;
    logic s_valid, m_ready;
    logic s_ready, m_valid;
    logic signed [QUAT_W-1:0] s_quat_w, s_quat_x, s_quat_y, s_quat_z;
    logic signed [YAW_W-1:0] m_yaw_deg, m_roll_deg;
    logic signed [PITCH_W-1:0] m_pitch_deg;
    logic m_pitch_clamped;

    angles_t angle_queue[$];
    int mismatches, results_seen, cycles;
    bit no_stall;

    quaternion_to_euler_angles u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_quat_w(s_quat_w), .s_quat_x(s_quat_x),
        .s_quat_y(s_quat_y), .s_quat_z(s_quat_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_yaw_deg(m_yaw_deg), .m_pitch_deg(m_pitch_deg),
        .m_roll_deg(m_roll_deg), .m_pitch_clamped(m_pitch_clamped)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint atan_step(input int i);
        longint t[ANG_TABLE_LEN] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
            58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
            4, 2, 1, 0};
        return t[i];
    endfunction

    function automatic longint floor_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    // vectoring cordic, angle in 2^-16 degree
    function automatic longint vector_angle(input longint vy, input longint vx);
        longint ang, xs, ys, mag, ux, uy;
        bit yneg;
        int sh;
        ang = 0;
        if (vx == 0 && vy == 0) return 0;
        if (vx < 0) begin
            ang = (vy >= 0) ? HALF : -HALF;
            vx = -vx;
            vy = -vy;
        end
        yneg = vy < 0;
        ux = vx;
        uy = yneg ? -vy : vy;
        mag = ux > uy ? ux : uy;
        sh = 0;
        while ((mag >> sh) >= (64'd1 << 30)) sh++;
        ux = ux >> sh;
        uy = uy >> sh;
        mag = mag >> sh;
        sh = 0;
        while ((mag << sh) < (64'd1 << 29)) sh++;
        vx = ux << sh;
        vy = yneg ? -(uy << sh) : (uy << sh);
        for (int i = 0; i < STAGES; i++) begin
            xs = floor_shr(vx, i);
            ys = floor_shr(vy, i);
            if (vy >= 0) begin
                vx += ys; vy -= xs; ang += atan_step(i);
            end else begin
                vx -= ys; vy += xs; ang -= atan_step(i);
            end
        end
        return ang;
    endfunction

    function automatic longint to_steps(input longint ang, input longint lim);
        longint v;
        v = floor_shr(ang + ROUND_BIAS, ROUND_SH);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v;
    endfunction

    function automatic longint int_sqrt(input longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic angles_t euler_of(input logic signed [QUAT_W-1:0] qw, qx, qy, qz);
        longint w, x, y, z, one, s, ms, s30, c;
        angles_t a;
        w = qw; x = qx; y = qy; z = qz;
        one = 64'sd1 <<< (2 * FRAC);
        a.clamped = 1'b0;
        a.yaw = YAW_W'(to_steps(vector_angle(2 * (x * y + w * z),
                                             w * w + x * x - y * y - z * z), YAW_LIM));
        a.roll = YAW_W'(to_steps(vector_angle(2 * (w * x + y * z),
                                              w * w - x * x - y * y + z * z), YAW_LIM));
        s = 2 * (x * z - w * y);
        // saturate the sine argument to unit magnitude
        if (s > one) begin
            s = one; a.clamped = 1'b1;
        end else if (s < -one) begin
            s = -one; a.clamped = 1'b1;
        end
        ms = s < 0 ? -s : s;
        s30 = (2 * FRAC >= 30) ? ms >> (2 * FRAC - 30) : ms << (30 - 2 * FRAC);
        c = int_sqrt((64'd1 << 60) - s30 * s30);
        a.pitch = PITCH_W'(to_steps(-vector_angle(s < 0 ? -s30 : s30, c), PITCH_LIM));
        return a;
    endfunction

    task automatic idle_burst(input int pct);
        if (!no_stall && $urandom_range(99) < pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(17, 1)) @(negedge aclk);
        end
    endtask

    task automatic send_quat(input logic signed [QUAT_W-1:0] qw, qx, qy, qz,
                             input bit fixed, input angles_t typed);
        angles_t a;
        a = euler_of(qw, qx, qy, qz);
        if (fixed && a != typed)
            $display("table row disagrees with predictor for %0d %0d %0d %0d",
                     qw, qx, qy, qz);
        s_valid <= 1'b1;
        s_quat_w <= qw; s_quat_x <= qx; s_quat_y <= qy; s_quat_z <= qz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        angle_queue.push_back(fixed ? typed : a);
        @(negedge aclk);
    endtask

    function automatic logic signed [QUAT_W-1:0] rand_comp(input int mode);
        case (mode)
            0: return QUAT_W'($urandom);
            1: return QUAT_W'($signed($urandom_range(32768)) - 16384);
            default: return QUAT_W'($signed($urandom_range(2048)) - 1024);
        endcase
    endfunction

    // unit quaternion from random angles, quantised to Q1.14
    task automatic rand_unit(output logic signed [QUAT_W-1:0] qw, qx, qy, qz);
        real a, b, c, n;
        a = ($urandom_range(1000000) / 1000000.0) * 6.283185307 - 3.14159265;
        b = ($urandom_range(1000000) / 1000000.0) * 3.14159265 - 1.5707963;
        c = ($urandom_range(1000000) / 1000000.0) * 6.283185307 - 3.14159265;
        n = 16384.0;
        qw = QUAT_W'($rtoi(n * ($cos(a/2)*$cos(b/2)*$cos(c/2) + $sin(a/2)*$sin(b/2)*$sin(c/2))));
        qx = QUAT_W'($rtoi(n * ($cos(a/2)*$cos(b/2)*$sin(c/2) - $sin(a/2)*$sin(b/2)*$cos(c/2))));
        qy = QUAT_W'($rtoi(n * ($cos(a/2)*$sin(b/2)*$cos(c/2) + $sin(a/2)*$cos(b/2)*$sin(c/2))));
        qz = QUAT_W'($rtoi(n * ($sin(a/2)*$cos(b/2)*$cos(c/2) - $cos(a/2)*$sin(b/2)*$sin(c/2))));
    endtask

    quat_row_t quat_table[] = '{
        '{16384, 0, 0, 0, 1, '{0, 0, 0, 0}},
        '{0, 0, 0, 0, 1, '{0, 0, 0, 0}},
        '{0, 0, 0, 16384, 1, '{23040, 0, 0, 0}},
        '{0, 16384, 0, 0, 1, '{0, 0, 23040, 0}},
        '{11585, 0, 11585, 0, 0, '{0, 0, 0, 0}},
        '{11585, 0, -11585, 0, 0, '{0, 0, 0, 0}},
        '{16384, 0, 16384, 0, 0, '{0, 0, 0, 0}},
        '{16384, 0, -16384, 0, 0, '{0, 0, 0, 0}},
        '{-16384, -16384, -16384, -16384, 0, '{0, 0, 0, 0}},
        '{16384, 16384, 16384, 16384, 0, '{0, 0, 0, 0}},
        '{-32768, -32768, -32768, -32768, 0, '{0, 0, 0, 0}},
        '{32767, 32767, 32767, 32767, 0, '{0, 0, 0, 0}},
        '{32767, -32768, 32767, -32768, 0, '{0, 0, 0, 0}},
        '{-16384, 0, 0, 0, 0, '{0, 0, 0, 0}},
        '{0, 0, 0, -16384, 0, '{0, 0, 0, 0}},
        '{1, 0, 0, -1, 0, '{0, 0, 0, 0}},
        '{0, 1, 1, 0, 0, '{0, 0, 0, 0}},
        '{14189, 8192, 0, 0, 0, '{0, 0, 0, 0}},
        '{-1, 0, -1, 0, 0, '{0, 0, 0, 0}},
        '{8192, 8192, 8192, 8192, 0, '{0, 0, 0, 0}}
    };

    // result checker
    always @(posedge aclk) begin
        angles_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (angle_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result yaw=%0d", m_yaw_deg);
            end else begin
                want = angle_queue.pop_front();
                if (m_yaw_deg !== want.yaw || m_pitch_deg !== want.pitch ||
                    m_roll_deg !== want.roll || m_pitch_clamped !== want.clamped) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 want.yaw, want.pitch, want.roll, want.clamped,
                                 m_yaw_deg, m_pitch_deg, m_roll_deg, m_pitch_clamped);
                end
            end
        end
    end

    // receiver back-pressure
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!no_stall && $urandom_range(99) < 15) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(17, 1)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_CAP) begin
                $display("timeout after %0d cycles", cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        logic signed [QUAT_W-1:0] qw, qx, qy, qz;
        int mode;
        mismatches = 0;
        results_seen = 0;
        no_stall = 1'b0;
        s_valid = 1'b0;
        s_quat_w = '0; s_quat_x = '0; s_quat_y = '0; s_quat_z = '0;
        aresetn = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (quat_table[i]) begin
            send_quat(quat_table[i].w, quat_table[i].x, quat_table[i].y, quat_table[i].z,
                      quat_table[i].fixed, quat_table[i].ang);
            idle_burst(20);
        end
        s_valid <= 1'b0;
        // drain fully before random traffic
        while (angle_queue.size() != 0) @(negedge aclk);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 200) no_stall = 1'b1;
            mode = $urandom_range(9);
            if (mode < 6) begin
                rand_unit(qw, qx, qy, qz);
            end else begin
                qw = rand_comp(mode - 6); qx = rand_comp(mode - 6);
                qy = rand_comp(mode - 6); qz = rand_comp(mode - 6);
            end
            send_quat(qw, qx, qy, qz, 1'b0, '{0, 0, 0, 0});
            idle_burst(10);
        end
        s_valid <= 1'b0;

        while (angle_queue.size() != 0) @(negedge aclk);
        repeat (LATENCY + 10) @(negedge aclk);
        $display("covered %0d directed and %0d random quaternions, %0d results checked",
                 quat_table.size(), N_RANDOM, results_seen);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
